@@ rtl/key_matrix_debounce_events_unit_defines.svh @@
// ----------------------------------------------------------------------------
// key matrix debounce events: assertion macros
// shared checks on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_DEBOUNCE_EVENTS_UNIT_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_EVENTS_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define KMDE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KMDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kmde_pkg.sv @@
// ----------------------------------------------------------------------------
// kmde_pkg
// types and constants shared by the key matrix debounce event block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmde_pkg;

  // field widths of the item formats
  localparam int unsigned RowW     = 3;
  localparam int unsigned BitsW    = 8;
  localparam int unsigned ColW     = 4;
  localparam int unsigned CntW     = 3;

  // default matrix geometry
  localparam int unsigned DefRows  = 8;
  localparam int unsigned DefCols  = 8;

  // configuration port
  localparam int unsigned AddrW    = 3;
  localparam int unsigned DataW    = 32;
  localparam logic        RegStableScans = 1'b0;
  localparam logic [CntW-1:0] StableScansRst = 3'd4;

  // input item: one scanned row
  typedef struct packed {
    logic [RowW-1:0]  row_index;
    logic [BitsW-1:0] row_bits;
  } in_item_t;

  // result item: one key event
  typedef struct packed {
    logic             pressed;
    logic [RowW-1:0]  event_row;
    logic [ColW-1:0]  event_column;
    logic             last_event;
  } out_item_t;

  // per-key result of one lane
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            state;
    logic            hit;
  } lane_res_t;

  // status of the event serialiser
  typedef struct packed {
    logic busy;
    logic more;
  } merge_stat_t;

endpackage

@@ rtl/kmde_lane.sv @@
// ----------------------------------------------------------------------------
// kmde_lane
// debounce rules for one key: counter update, state change and event flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmde_lane (
  input  logic                       sample_i,
  input  logic                       last_i,
  input  logic                       state_i,
  input  logic [kmde_pkg::CntW-1:0]  cnt_i,
  input  logic [kmde_pkg::CntW-1:0]  thr_i,
  output kmde_pkg::lane_res_t        res_o
);

  logic                      vs_last;
  logic                      vs_state;
  logic [kmde_pkg::CntW-1:0] cnt_inc;

  assign vs_last  = sample_i ^ last_i;
  assign vs_state = sample_i ^ state_i;
  assign cnt_inc  = cnt_i + kmde_pkg::CntW'(1);

  // clear on a fresh change, count while stable and not yet accepted
  always_comb begin
    res_o.cnt   = cnt_i;
    res_o.state = state_i;
    res_o.hit   = 1'b0;
    if (vs_last && vs_state) begin
      res_o.cnt = '0;
    end else if (!vs_last && vs_state && (cnt_i < thr_i)) begin
      res_o.cnt = cnt_inc;
      if (cnt_inc == thr_i) begin
        res_o.hit   = 1'b1;
        res_o.state = sample_i;
      end
    end
  end

endmodule

@@ rtl/kmde_merge.sv @@
// ----------------------------------------------------------------------------
// kmde_merge
// gathers the lane hits of one item and sends them out one per cycle while the output is ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmde_merge #(
  parameter int unsigned Lanes = kmde_pkg::DefCols
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_i,
  input  logic [Lanes-1:0]           hit_mask_i,
  input  logic [Lanes-1:0]           press_mask_i,
  input  logic [kmde_pkg::RowW-1:0]  row_i,
  output logic                       can_load_o,
  output logic [Lanes-1:0]           pend_o,
  output kmde_pkg::merge_stat_t      stat_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output kmde_pkg::out_item_t        out_item_o
);

  logic [Lanes-1:0]          pend_q, pend_d;
  logic [Lanes-1:0]          press_q;
  logic [kmde_pkg::RowW-1:0] row_q;
  logic                      ov_q, ov_d;
  kmde_pkg::out_item_t       item_q, item_d;
  logic [Lanes-1:0]          sel_oh;
  logic [kmde_pkg::ColW-1:0] sel_col;
  logic                      sel_press;
  logic [Lanes-1:0]          rest;
  logic                      pop;

  // lowest pending column goes first
  always_comb begin
    sel_oh    = '0;
    sel_col   = '0;
    sel_press = 1'b0;
    for (int c = Lanes - 1; c >= 0; c--) begin
      if (pend_q[c]) begin
        sel_oh    = '0;
        sel_oh[c] = 1'b1;
        sel_col   = kmde_pkg::ColW'(c);
        sel_press = press_q[c];
      end
    end
  end

  assign rest       = pend_q & ~sel_oh;
  assign pop        = (|pend_q) && (!ov_q || out_ready_i);
  assign can_load_o = (pend_q == '0) || (pop && (rest == '0));

  // pending events and output register
  always_comb begin
    pend_d = pend_q;
    ov_d   = ov_q;
    item_d = item_q;
    if (pop) begin
      pend_d              = rest;
      ov_d                = 1'b1;
      item_d.pressed      = sel_press;
      item_d.event_row    = row_q;
      item_d.event_column = sel_col;
      item_d.last_event   = (rest == '0);
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (load_i) begin
      pend_d = hit_mask_i;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      pend_q <= pend_d;
      ov_q   <= ov_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (load_i) begin
      press_q <= press_mask_i;
      row_q   <= row_i;
    end
  end

  assign pend_o      = pend_q;
  assign stat_o.busy = |pend_q;
  assign stat_o.more = |rest;
  assign out_valid_o = ov_q;
  assign out_item_o  = item_q;

endmodule

@@ rtl/key_matrix_debounce_events_unit.sv @@
// the hits of an accepted row are registered in the pending mask, then its first event in the output register
// throughput: one item per cycle while rows cause no events; a row with events
//   holds the event serialiser until its last event is sent, one event per cycle while the output is ready
// all column lanes update a row in the accept cycle, so rows may repeat back to back
// reset: all keys up, all counters zero, stable_scans 4, no events outstanding
// ----------------------------------------------------------------------------
// key_matrix_debounce_events_unit
// key matrix debouncer that emits press and release events per scanned row
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_matrix_debounce_events_unit_defines.svh"

module key_matrix_debounce_events_unit #(
  parameter int unsigned ROWS = kmde_pkg::DefRows,
  parameter int unsigned COLS = kmde_pkg::DefCols
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // row items
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  kmde_pkg::in_item_t          in_item_i,
  // event items
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output kmde_pkg::out_item_t         out_item_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kmde_pkg::AddrW-1:0]  paddr,
  input  logic [kmde_pkg::DataW-1:0]  pwdata,
  output logic [kmde_pkg::DataW-1:0]  prdata,
  output logic                        pready
);

  localparam int unsigned Lanes = (COLS < kmde_pkg::BitsW) ? COLS : kmde_pkg::BitsW;
  localparam int unsigned RIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [kmde_pkg::CntW-1:0] scans_q;
  logic [kmde_pkg::CntW-1:0] thr;
  logic [Lanes-1:0]          prev_q [ROWS];
  logic [Lanes-1:0]          deb_q  [ROWS];
  logic [kmde_pkg::CntW-1:0] cnt_q  [ROWS][Lanes];
  logic [RIdxW-1:0]          ri;
  logic                      row_ok;
  logic                      in_acc;
  logic                      upd;
  logic [Lanes-1:0]          sample;
  logic [Lanes-1:0]          last_row;
  logic [Lanes-1:0]          state_row;
  logic [Lanes-1:0]          hit_mask;
  logic [Lanes-1:0]          state_new;
  kmde_pkg::lane_res_t       res [Lanes];
  logic                      can_load;
  logic [Lanes-1:0]          pend;
  kmde_pkg::merge_stat_t     mstat;
  logic                      cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scans_q <= kmde_pkg::StableScansRst;
    end else if (cfg_wr && (paddr[kmde_pkg::AddrW-1] == kmde_pkg::RegStableScans)) begin
      scans_q <= pwdata[kmde_pkg::CntW-1:0];
    end
  end

  assign prdata = (paddr[kmde_pkg::AddrW-1] == kmde_pkg::RegStableScans) ?
                  kmde_pkg::DataW'(scans_q) : '0;

  // a zero threshold acts as one
  assign thr = (scans_q == '0) ? kmde_pkg::CntW'(1) : scans_q;

  // row selection and acceptance
  assign row_ok     = (4'(in_item_i.row_index) < 4'(ROWS));
  assign ri         = in_item_i.row_index[RIdxW-1:0];
  assign in_ready_o = can_load;
  assign in_acc     = in_valid_i && in_ready_o;
  assign upd        = in_acc && row_ok;
  assign sample     = ~in_item_i.row_bits[Lanes-1:0];
  assign last_row   = prev_q[ri];
  assign state_row  = deb_q[ri];

  // one lane per scanned column
  for (genvar c = 0; c < Lanes; c++) begin : g_lane
    kmde_lane u_lane (
      .sample_i (sample[c]),
      .last_i   (last_row[c]),
      .state_i  (state_row[c]),
      .cnt_i    (cnt_q[ri][c]),
      .thr_i    (thr),
      .res_o    (res[c])
    );
    assign hit_mask[c]  = res[c].hit;
    assign state_new[c] = res[c].state;
  end

  // per-key stores, written back in the accept cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        prev_q[r] <= '0;
        deb_q[r]  <= '0;
        for (int c = 0; c < Lanes; c++) begin
          cnt_q[r][c] <= '0;
        end
      end
    end else if (upd) begin
      prev_q[ri] <= sample;
      deb_q[ri]  <= state_new;
      for (int c = 0; c < Lanes; c++) begin
        cnt_q[ri][c] <= res[c].cnt;
      end
    end
  end

  // event serialiser
  kmde_merge #(
    .Lanes (Lanes)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (upd),
    .hit_mask_i   (hit_mask),
    .press_mask_i (sample),
    .row_i        (in_item_i.row_index),
    .can_load_o   (can_load),
    .pend_o       (pend),
    .stat_o       (mstat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

  // checks
  `KMDE_ASSERT_NOW(a_ready_one_left, in_ready_o && mstat.busy, $countones(pend) == 1,
    "ready raised with more than one event outstanding")
  `KMDE_ASSERT_NEXT(a_load_hits, upd, pend == $past(hit_mask),
    "accepted row hits not taken into the serialiser")
  `KMDE_ASSERT_NOW(a_not_last_pending, out_valid_o && !out_item_o.last_event, mstat.busy,
    "non-final event shown with nothing left pending")

endmodule

@@ test/key_matrix_debounce_events_unit_tb.sv @@
// ----------------------------------------------------------------------------
// key_matrix_debounce_events_unit_tb
// drives scanned rows into the debouncer, predicts the press and release
// events of every row item and checks each event item field by field; the
// threshold is reprogrammed between phases over its whole range
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_debounce_events_unit_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [kmde_pkg::AddrW-1:0] ScansAddr =
    kmde_pkg::AddrW'(4 * kmde_pkg::RegStableScans);
  localparam int unsigned PhaseRows = 50;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  kmde_pkg::in_item_t  in_item_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  kmde_pkg::out_item_t out_item_o;

  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [kmde_pkg::AddrW-1:0]     paddr = '0;
  logic [kmde_pkg::DataW-1:0]     pwdata = '0;
  logic [kmde_pkg::DataW-1:0]     prdata;
  logic                           pready;

  // rows waiting for the driver, events waiting for the block
  kmde_pkg::in_item_t  pending_rows[$];
  kmde_pkg::out_item_t predicted_events[$];

  // shadow of the debouncer state
  logic [2:0] scans_setting = kmde_pkg::StableScansRst;
  logic [7:0] last_scan [8];
  logic [7:0] key_state [8];
  logic [2:0] key_count [64];

  bit          steady_flow = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned rows_accepted = 0;
  int unsigned events_checked = 0;
  int unsigned settings_used = 1;
  kmde_pkg::out_item_t wanted_event;

  key_matrix_debounce_events_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 2 ns clock
  always #1 clk_i = ~clk_i;

  function automatic string event_text(input kmde_pkg::out_item_t ev);
    return $sformatf("pressed %0b row %0d col %0d last %0b",
                     ev.pressed, ev.event_row, ev.event_column, ev.last_event);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // apply one row to the shadow state and queue the events it causes
  task automatic debounce_row(input kmde_pkg::in_item_t it);
    logic [7:0] sample;
    logic [7:0] last;
    logic [7:0] state;
    logic [2:0] thr;
    logic [5:0] key;
    kmde_pkg::out_item_t ev;
    kmde_pkg::out_item_t row_events[$];
    sample = ~it.row_bits;
    thr = (scans_setting == 3'd0) ? 3'd1 : scans_setting;
    last = last_scan[it.row_index];
    state = key_state[it.row_index];
    for (int c = 0; c < 8; c++) begin
      key = {it.row_index, 3'(c)};
      if (sample[c] != last[c] && sample[c] != state[c]) begin
        key_count[key] = 3'd0;
      end else if (sample[c] == last[c] && sample[c] != state[c]) begin
        // a counter left above a lowered threshold stays frozen
        if (key_count[key] < thr) begin
          key_count[key] = key_count[key] + 3'd1;
          if (key_count[key] == thr) begin
            state[c] = sample[c];
            ev.pressed = sample[c];
            ev.event_row = it.row_index;
            ev.event_column = 4'(c);
            ev.last_event = 1'b0;
            row_events.push_back(ev);
          end
        end
      end
    end
    last_scan[it.row_index] = sample;
    key_state[it.row_index] = state;
    for (int i = 0; i < row_events.size(); i++) begin
      ev = row_events[i];
      ev.last_event = (i == row_events.size() - 1);
      predicted_events.push_back(ev);
    end
  endtask

  // row driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_rows.size() != 0 && (steady_flow || $urandom_range(99) >= 35)) begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_rows.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // event sink back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady_flow || ($urandom_range(99) >= 35);
    end
  end

  // monitor: predict on accepted rows, check accepted events
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        debounce_row(in_item_i);
        rows_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (predicted_events.size() == 0) begin
          report_mismatch({"unexpected event ", event_text(out_item_o)});
        end else begin
          wanted_event = predicted_events.pop_front();
          events_checked++;
          if (out_item_o.pressed !== wanted_event.pressed ||
              out_item_o.event_row !== wanted_event.event_row ||
              out_item_o.event_column !== wanted_event.event_column ||
              out_item_o.last_event !== wanted_event.last_event) begin
            report_mismatch({"expected ", event_text(wanted_event),
                             ", got ", event_text(out_item_o)});
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycle_count, predicted_events.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_row(input logic [2:0] row, input logic [7:0] bits);
    kmde_pkg::in_item_t it;
    it.row_index = row;
    it.row_bits = bits;
    pending_rows.push_back(it);
  endtask

  task automatic queue_repeat(input logic [2:0] row, input logic [7:0] bits, input int n);
    for (int i = 0; i < n; i++) queue_row(row, bits);
  endtask

  // wait until every row is taken and every event has come out
  task automatic wait_drained();
    while (pending_rows.size() != 0 || in_valid_i || predicted_events.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ScansAddr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write the threshold, then read it back
  task automatic set_scans(input logic [2:0] value);
    logic [31:0] readback;
    apb_xfer(1'b1, 32'(value), readback);
    scans_setting = value;
    settings_used++;
    apb_xfer(1'b0, '0, readback);
    if (readback !== 32'(value))
      report_mismatch($sformatf("stable_scans read %0h, wrote %0h", readback, value));
    @(negedge clk_i);
  endtask

  // bursts of repeated row patterns with occasional bounce, plus raw noise
  task automatic queue_random_rows(input int n);
    int made;
    int reps;
    int thr;
    logic [2:0] row;
    logic [7:0] target;
    logic [7:0] bits;
    made = 0;
    thr = (scans_setting == 3'd0) ? 1 : scans_setting;
    while (made < n) begin
      row = 3'($urandom_range(7));
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(9))
          0: target = 8'h00;
          1: target = 8'hff;
          default: target = 8'($urandom_range(255));
        endcase
        reps = $urandom_range(thr + 2, 1);
        for (int i = 0; i < reps; i++) begin
          bits = target;
          if ($urandom_range(99) < 10) bits[$urandom_range(7)] = ~bits[$urandom_range(7)];
          queue_row(row, bits);
        end
        made += reps;
      end else begin
        queue_row(row, 8'($urandom_range(255)));
        made++;
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    logic [2:0] phase_scans [8];
    logic [31:0] readback;
    phase_scans = '{3'd7, 3'd2, 3'd0, 3'd5, 3'd1, 3'd6, 3'd3, 3'd4};
    for (int r = 0; r < 8; r++) begin
      last_scan[r] = '0;
      key_state[r] = '0;
    end
    for (int k = 0; k < 64; k++) key_count[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset value of the threshold
    apb_xfer(1'b0, '0, readback);
    if (readback !== 32'(kmde_pkg::StableScansRst))
      report_mismatch($sformatf("stable_scans reset read %0h", readback));
    @(negedge clk_i);

    // default threshold: full row press, single corner key, settled row
    queue_repeat(3'd0, 8'h00, 5);
    queue_repeat(3'd7, 8'h7f, 5);
    queue_row(3'd0, 8'h00);
    wait_drained();

    // threshold one: bounce back, release, alternating columns
    set_scans(3'd1);
    queue_row(3'd0, 8'hff);
    queue_row(3'd0, 8'h00);
    queue_repeat(3'd0, 8'hff, 2);
    queue_repeat(3'd3, 8'h55, 2);
    queue_repeat(3'd3, 8'haa, 2);
    wait_drained();

    // zero threshold behaves as one
    set_scans(3'd0);
    queue_repeat(3'd6, 8'h00, 2);
    queue_repeat(3'd6, 8'hff, 2);
    wait_drained();

    // random phases, keeping part-way counters across threshold changes
    for (int p = 0; p < 8; p++) begin
      set_scans(phase_scans[p]);
      steady_flow = (p == 3);
      queue_random_rows(PhaseRows);
      wait_drained();
    end
    steady_flow = 1'b0;
    repeat (10) @(negedge clk_i);

    if (predicted_events.size() != 0)
      report_mismatch($sformatf("%0d events never arrived", predicted_events.size()));
    $display("%0d rows scanned, %0d events checked, %0d threshold settings, %0d mismatches",
             rows_accepted, events_checked, settings_used, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/kmde_pkg.sv
rtl/kmde_lane.sv
rtl/kmde_merge.sv
rtl/key_matrix_debounce_events_unit.sv
test/key_matrix_debounce_events_unit_tb.sv
